### hdl/ifd_pkg.sv
package ifd_pkg;

	// Default number of 32-bit data words in one frame.
	localparam int unsigned WORD_COUNT_DEF = 18;

	localparam logic [7:0] HDR_PREAMBLE    = 8'hFA;
	localparam logic [7:0] BUS_ID_RESET    = 8'hFF;
	localparam logic [7:0] MSG_ID_RESET    = 8'h32;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned INDEX_W  = 5;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BUS_ID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_ID = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] bus_id;
		logic [BYTE_W-1:0] msg_id;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic               last;
	} result_t;

	typedef struct packed {
		logic in_frame;
	} status_t;

endpackage

### hdl/ifd_parser.sv
module ifd_parser #(
	parameter int unsigned WORD_COUNT = ifd_pkg::WORD_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [ifd_pkg::BYTE_W-1:0] rx_byte,
	input  ifd_pkg::cfg_t            cfg,
	output ifd_pkg::result_t         res,
	output ifd_pkg::status_t         status
);
	import ifd_pkg::*;

	localparam int unsigned POS_W = $clog2(4 * WORD_COUNT + 4);
	localparam logic [POS_W-1:0] STATUS_POS  = POS_W'(4 * WORD_COUNT);
	localparam logic [POS_W-1:0] CNT_HI_POS  = POS_W'(4 * WORD_COUNT + 1);
	localparam logic [POS_W-1:0] CNT_END_POS = POS_W'(4 * WORD_COUNT + 2);
	localparam logic [BYTE_W-1:0] HDR_LENGTH = BYTE_W'(4 * WORD_COUNT + 3);
	localparam logic [INDEX_W-1:0] STATUS_IDX  = INDEX_W'(WORD_COUNT);
	localparam logic [INDEX_W-1:0] COUNTER_IDX = INDEX_W'(WORD_COUNT + 1);

	logic                in_frame_q;
	logic [23:0]         recent_q;
	logic [POS_W-1:0]    pos_q;
	logic [VALUE_W-1:0]  acc_q;

	logic                in_frame_d;
	logic [23:0]         recent_d;
	logic [POS_W-1:0]    pos_d;
	logic [VALUE_W-1:0]  acc_d;
	logic [VALUE_W-1:0]  acc_shift;
	logic [7:0]          pos_ext;
	logic                hdr_hit;

	assign acc_shift = {acc_q[VALUE_W-BYTE_W-1:0], rx_byte};
	assign pos_ext   = 8'(pos_q);
	assign hdr_hit   = (recent_q == {HDR_PREAMBLE, cfg.bus_id, cfg.msg_id})
		&& (rx_byte == HDR_LENGTH);

	always_comb begin
		in_frame_d = in_frame_q;
		recent_d   = recent_q;
		pos_d      = pos_q;
		acc_d      = acc_q;
		res        = '0;
		if (!in_frame_q) begin
			if (hdr_hit) begin
				in_frame_d = 1'b1;
				pos_d      = '0;
				acc_d      = '0;
				recent_d   = '0;
			end else begin
				recent_d = {recent_q[15:0], rx_byte};
			end
		end else begin
			if (pos_q < STATUS_POS) begin
				acc_d = acc_shift;
				if (pos_q[1:0] == 2'b11) begin
					res.valid = 1'b1;
					res.index = pos_ext[6:2];
					res.value = acc_shift;
					acc_d     = '0;
				end
			end else if (pos_q == STATUS_POS) begin
				res.valid = 1'b1;
				res.index = STATUS_IDX;
				res.value = VALUE_W'(rx_byte);
				acc_d     = '0;
			end else if (pos_q == CNT_HI_POS) begin
				acc_d = VALUE_W'(rx_byte);
			end else if (pos_q == CNT_END_POS) begin
				res.valid = 1'b1;
				res.index = COUNTER_IDX;
				res.value = VALUE_W'({acc_q[7:0], rx_byte});
				res.last  = 1'b1;
				acc_d     = '0;
			end
			// The checksum byte closes the frame without being checked.
			if (pos_q > CNT_END_POS) begin
				in_frame_d = 1'b0;
				pos_d      = '0;
				acc_d      = '0;
			end else begin
				pos_d = pos_q + 1'b1;
			end
		end
		if (!take) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			recent_q   <= '0;
			pos_q      <= '0;
			acc_q      <= '0;
		end else if (take) begin
			in_frame_q <= in_frame_d;
			recent_q   <= recent_d;
			pos_q      <= pos_d;
			acc_q      <= acc_d;
		end
	end

	assign status.in_frame = in_frame_q;

endmodule

### hdl/imu_frame_deframer_unit.sv
// A result appears on the master side in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle; the input is stalled only while a result waits unread.
// Each byte is parsed by combinational logic in front of one output register.
// Reset (arst_n low, asynchronous) clears the search window and frame state and
// returns the bus id to 0xFF and the message id to 0x32.
module imu_frame_deframer_unit #(
	parameter int unsigned WORD_COUNT = ifd_pkg::WORD_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,   // [4:0] field_index, [36:5] field_value
	output logic                          m_tlast,   // frame_last
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ifd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import ifd_pkg::*;

	cfg_t               cfg_q;
	result_t            res;
	status_t            status;
	logic               s_take;
	logic               m_tvalid_q;
	logic [INDEX_W-1:0] index_q;
	logic [VALUE_W-1:0] value_q;
	logic               last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_id <= BUS_ID_RESET;
			cfg_q.msg_id <= MSG_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUS_ID: cfg_q.bus_id <= cfg_data;
				REG_MSG_ID: cfg_q.msg_id <= cfg_data;
				default: ;
			endcase
		end
	end

	// A new byte is taken whenever the output register is empty or being drained.
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_take   = s_tvalid && s_tready;

	ifd_parser #(
		.WORD_COUNT(WORD_COUNT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (s_take),
		.rx_byte (s_tdata),
		.cfg     (cfg_q),
		.res     (res),
		.status  (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			index_q <= res.index;
			value_q <= res.value;
			last_q  <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, value_q, index_q};
	assign m_tlast  = last_q;

	a_no_result_while_searching: assert property (@(posedge clk) disable iff (!arst_n)
		!status.in_frame |-> !res.valid)
		else $error("result produced during header search");

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> s_take)
		else $error("result produced without an input transaction");

	a_last_is_counter: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[4:0] == INDEX_W'(WORD_COUNT + 1))
		else $error("last flag on a field other than the sample counter");

	a_frame_continues_after_counter: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last |=> status.in_frame)
		else $error("frame closed before the checksum byte");

endmodule

### bench/imu_frame_deframer_unit_tb.sv
module imu_frame_deframer_unit_tb;
	import ifd_pkg::*;

	localparam int unsigned WC           = WORD_COUNT_DEF;
	localparam int unsigned STATUS_POS   = 4 * WC;
	localparam int unsigned COUNTER_END  = STATUS_POS + 2;
	localparam int unsigned CHECKSUM_POS = STATUS_POS + 3;
	localparam logic [7:0]  LEN_BYTE     = 8'(4 * WC + 3);
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned PHASE_BYTES  = 175;
	localparam int unsigned NUM_PHASES   = 6;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef enum int {BODY_RANDOM, BODY_ZERO, BODY_ONES, BODY_FAKE_HDR} body_style_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic               last;
	} field_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [39:0]          m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	imu_frame_deframer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Stimulus side.
	logic [7:0]  rx_bytes_q[$];
	int unsigned bytes_sent = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic [7:0]  hdr_bus = BUS_ID_RESET;
	logic [7:0]  hdr_msg = MSG_ID_RESET;

	// Handshake flags seen at the last rising edge.
	logic s_took = 1'b0;
	logic cfg_took = 1'b0;

	// Deframer state mirrored for prediction.
	logic [7:0]  bus_id_reg = BUS_ID_RESET;
	logic [7:0]  msg_id_reg = MSG_ID_RESET;
	logic [23:0] hunt_window = '0;
	logic        frame_open = 1'b0;
	logic [7:0]  frame_pos = '0;
	logic [31:0] field_acc = '0;
	field_rec_t  fields_due[$];

	int unsigned bytes_taken = 0;
	int unsigned fields_checked = 0;
	int unsigned frames_done = 0;
	int unsigned fail_count = 0;
	int unsigned stall_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	task automatic push_field(input int unsigned idx, input logic [31:0] val, input logic lst);
		field_rec_t f;
		f.index = idx[INDEX_W-1:0];
		f.value = val;
		f.last  = lst;
		fields_due.push_back(f);
	endtask

	// Advances the mirrored deframer by one accepted byte.
	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] pos;
		pos = frame_pos;
		if (!frame_open) begin
			if (hunt_window == {HDR_PREAMBLE, bus_id_reg, msg_id_reg} && b == LEN_BYTE) begin
				frame_open  = 1'b1;
				frame_pos   = '0;
				field_acc   = '0;
				hunt_window = '0;
			end else begin
				hunt_window = {hunt_window[15:0], b};
			end
		end else begin
			if (pos < STATUS_POS) begin
				field_acc = {field_acc[23:0], b};
				if (pos[1:0] == 2'd3) begin
					push_field(32'(pos[7:2]), field_acc, 1'b0);
					field_acc = '0;
				end
			end else if (pos == STATUS_POS) begin
				push_field(WC, {24'h0, b}, 1'b0);
				field_acc = '0;
			end else if (pos < COUNTER_END) begin
				field_acc = {24'h0, b};
			end else if (pos == COUNTER_END) begin
				field_acc = {16'h0, field_acc[7:0], b};
				push_field(WC + 1, field_acc, 1'b1);
				field_acc = '0;
			end
			if (pos >= CHECKSUM_POS) begin
				frame_open = 1'b0;
				frame_pos  = '0;
				field_acc  = '0;
			end else begin
				frame_pos = pos + 8'd1;
			end
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			// A presented byte is held until its transaction completes.
			if (!s_tvalid || s_took) begin
				if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= rx_bytes_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		logic       s_fire, m_fire, c_fire;
		field_rec_t want;
		s_fire = arst_n && s_tvalid && s_tready;
		m_fire = arst_n && m_tvalid && m_tready;
		c_fire = arst_n && cfg_valid && cfg_ready;
		if (c_fire) begin
			if (cfg_index == REG_BUS_ID)
				bus_id_reg = cfg_data;
			else if (cfg_index == REG_MSG_ID)
				msg_id_reg = cfg_data;
		end
		if (s_fire) begin
			deframe_byte(s_tdata);
			bytes_taken <= bytes_taken + 1;
		end
		if (m_fire) begin
			fields_checked <= fields_checked + 1;
			if (m_tlast)
				frames_done <= frames_done + 1;
			if (fields_due.size() == 0) begin
				note_fail($sformatf("unexpected field index %0d value %h last %b",
					m_tdata[4:0], m_tdata[36:5], m_tlast));
			end else begin
				want = fields_due.pop_front();
				if (m_tdata[4:0] !== want.index || m_tdata[36:5] !== want.value ||
						m_tlast !== want.last || m_tdata[39:37] !== 3'b000)
					note_fail($sformatf({"expected index %0d value %h last %b, ",
						"got index %0d value %h last %b pad %b"},
						want.index, want.value, want.last,
						m_tdata[4:0], m_tdata[36:5], m_tlast, m_tdata[39:37]));
			end
		end
		s_took   <= s_fire;
		cfg_took <= c_fire;
		if (s_fire || m_fire || c_fire) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic put(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_sent++;
	endtask

	task automatic put_header();
		put(HDR_PREAMBLE);
		put(hdr_bus);
		put(hdr_msg);
		put(LEN_BYTE);
	endtask

	// Payload words, status, sample counter and the unchecked checksum byte.
	task automatic put_body(input body_style_t style, input logic [7:0] status,
			input logic [15:0] count);
		int unsigned cut;
		cut = $urandom_range(0, STATUS_POS - 4);
		for (int unsigned i = 0; i < STATUS_POS; i++) begin
			case (style)
				BODY_ZERO: put(8'h00);
				BODY_ONES: put(8'hFF);
				BODY_FAKE_HDR: begin
					if (i == cut)
						put(HDR_PREAMBLE);
					else if (i == cut + 1)
						put(hdr_bus);
					else if (i == cut + 2)
						put(hdr_msg);
					else if (i == cut + 3)
						put(LEN_BYTE);
					else
						put(8'($urandom));
				end
				default: put(8'($urandom));
			endcase
		end
		put(status);
		put(count[15:8]);
		put(count[7:0]);
		put(8'($urandom));
	endtask

	task automatic queue_random(input int unsigned budget);
		int unsigned start, pick;
		body_style_t style;
		logic [7:0]  status;
		logic [15:0] count;
		logic [7:0]  hdr[4];
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				if ($urandom_range(0, 9) < 6)
					style = BODY_RANDOM;
				else
					style = body_style_t'($urandom_range(1, 3));
				case ($urandom_range(0, 3))
					0: status = 8'h00;
					1: status = 8'hFF;
					default: status = 8'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: count = 16'h0000;
					1: count = 16'hFFFF;
					default: count = 16'($urandom);
				endcase
				put_header();
				put_body(style, status, count);
			end else if (pick < 8) begin
				// A header with one byte spoiled.
				hdr = '{HDR_PREAMBLE, hdr_bus, hdr_msg, LEN_BYTE};
				pick = $urandom_range(0, 3);
				hdr[pick] = hdr[pick] ^ 8'($urandom_range(1, 255));
				foreach (hdr[k])
					put(hdr[k]);
			end else if ($urandom_range(0, 2) == 0) begin
				// Zeros left in a cleared window must not pass for a header.
				put(8'h00);
				put(8'h00);
				put(LEN_BYTE);
			end else begin
				repeat ($urandom_range(1, 6))
					put(($urandom_range(0, 3) == 0) ? HDR_PREAMBLE : 8'($urandom));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
		if (idx == REG_BUS_ID)
			hdr_bus = val;
		else
			hdr_msg = val;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (bytes_taken != bytes_sent || fields_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				1: begin
					write_reg(REG_BUS_ID, 8'h00);
					write_reg(REG_MSG_ID, 8'h00);
				end
				2: begin
					write_reg(REG_BUS_ID, 8'hFF);
					write_reg(REG_MSG_ID, 8'hFF);
				end
				3: begin
					write_reg(REG_MSG_ID, 8'($urandom));
					write_reg(REG_BUS_ID, 8'($urandom));
				end
				4: begin
					// Ids equal to the preamble and length bytes invite false overlaps.
					write_reg(REG_BUS_ID, HDR_PREAMBLE);
					write_reg(REG_MSG_ID, LEN_BYTE);
				end
				5: begin
					write_reg(REG_BUS_ID, BUS_ID_RESET);
					write_reg(REG_MSG_ID, MSG_ID_RESET);
				end
				default: ;
			endcase
			@(posedge clk);
			tx_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 87 : 0;
			rx_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 11 : 0;
			if (ph == 0) begin
				put(8'h00);
				put(8'hFF);
				put(HDR_PREAMBLE); put(hdr_bus); put(hdr_msg); put(LEN_BYTE + 8'd1);
				put(HDR_PREAMBLE); put(hdr_bus - 8'd1); put(hdr_msg); put(LEN_BYTE);
				put(HDR_PREAMBLE); put(hdr_bus); put(hdr_msg + 8'd1); put(LEN_BYTE);
				put(HDR_PREAMBLE + 8'd1); put(hdr_bus); put(hdr_msg); put(LEN_BYTE);
				// Real header starting inside a failed candidate.
				put(HDR_PREAMBLE);
				put(hdr_bus);
				put(HDR_PREAMBLE);
				put_header();
				put_body(BODY_ONES, 8'h00, 16'h0000);
				// Back to back frames: search restarts right after the checksum.
				put_header();
				put_body(BODY_ZERO, 8'hFF, 16'hFFFF);
				put_header();
				put_body(BODY_FAKE_HDR, 8'($urandom), 16'($urandom));
			end
			queue_random(PHASE_BYTES);
		end
		wait_drained();
		fail_count += fields_due.size();
		$display("Streamed %0d bytes over %0d id settings with idle and stall patterns.",
			bytes_taken, NUM_PHASES);
		$display("Compared %0d fields from %0d frames; %0d failures.",
			fields_checked, frames_done, fail_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### imu_frame_deframer_unit.f
hdl/ifd_pkg.sv
hdl/ifd_parser.sv
hdl/imu_frame_deframer_unit.sv
bench/imu_frame_deframer_unit_tb.sv
